// ===== rtl/array_list_engine_core_macros.svh =====
// Assertion macros used by the checker file of the array list engine.
`ifndef ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`define ARRAY_LIST_ENGINE_CORE_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ALEN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ALEN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/alen_pkg.sv =====
// Package with the types and constants of the array list engine.
`timescale 1ns / 1ps
`default_nettype none

package alen_pkg;

  localparam int ALEN_DEPTH      = 128;
  localparam int ALEN_WORD_WIDTH = 32;

  localparam int OP_W     = 2;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int LENGTH_W = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2
  } alen_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } alen_status_e;

  typedef struct packed {
    alen_op_e            op;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   word_in;
  } alen_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]   word_out;
    logic [LENGTH_W-1:0] length;
    alen_status_e        status;
  } alen_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         req_load;
    logic         do_append;
    logic         rd_pos;
    logic         rd_ptr_init;
    logic         shift_step;
    logic         cnt_dec;
    logic         res_write;
    logic         res_from_rd;
    alen_status_e res_status;
    logic         out_load;
  } alen_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    alen_op_e op;
    logic     pos_ok;
    logic     full;
    logic     init_more;
    logic     step_more;
    logic     out_busy;
  } alen_stat_t;

endpackage

`default_nettype wire

// ===== rtl/alen_dpath.sv =====
// Datapath of the array list engine: entry memory, count, shift pointer and result registers.
`timescale 1ns / 1ps
`default_nettype none

module alen_dpath
  import alen_pkg::*;
#(
  parameter int DEPTH      = ALEN_DEPTH,
  parameter int WORD_WIDTH = ALEN_WORD_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  alen_in_t   in_data_i,
  input  logic       out_stall_i,
  input  alen_cmd_t  cmd_i,
  output alen_stat_t stat_o,
  output alen_out_t  out_data_o,
  output logic       out_valid_o
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int XW    = (WORD_WIDTH > DATA_W) ? WORD_WIDTH : DATA_W;

  logic [WORD_WIDTH-1:0] mem_q [DEPTH];
  logic [WORD_WIDTH-1:0] rdata_q;

  alen_in_t           req_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [AW-1:0]      ptr_q;
  logic [DATA_W-1:0]  res_word_q;
  alen_status_e       res_status_q;
  alen_out_t          out_q;
  logic               out_valid_q, out_valid_d;

  logic [CW-1:0]         pos_ext, cnt_ext, pos_nxt, ptr_nxt;
  logic [XW-1:0]         in_ext, rd_ext;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [WORD_WIDTH-1:0] mem_wdata;

  assign pos_ext = CW'(req_q.position);
  assign cnt_ext = CW'(count_q);
  assign pos_nxt = pos_ext + CW'(1);
  assign ptr_nxt = CW'(ptr_q) + CW'(1);
  assign in_ext  = XW'(req_q.word_in);
  assign rd_ext  = XW'(rdata_q);

  assign stat_o.op        = req_q.op;
  assign stat_o.pos_ok    = pos_ext < cnt_ext;
  assign stat_o.full      = count_q == CNT_W'(DEPTH);
  assign stat_o.init_more = pos_nxt < cnt_ext;
  assign stat_o.step_more = ptr_nxt < cnt_ext;
  assign stat_o.out_busy  = out_valid_q & out_stall_i;

  // A shift step writes the word fetched last cycle one place down and
  // fetches the next word in the same cycle.
  always_comb begin
    mem_we    = cmd_i.do_append | cmd_i.shift_step;
    mem_waddr = cmd_i.do_append ? AW'(count_q) : (ptr_q - AW'(1));
    mem_wdata = cmd_i.do_append ? in_ext[WORD_WIDTH-1:0] : rdata_q;
    mem_re    = cmd_i.rd_pos | cmd_i.rd_ptr_init | (cmd_i.shift_step & stat_o.step_more);
    if (cmd_i.rd_pos) begin
      mem_raddr = AW'(pos_ext);
    end else if (cmd_i.rd_ptr_init) begin
      mem_raddr = AW'(pos_nxt);
    end else begin
      mem_raddr = AW'(ptr_nxt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.rd_ptr_init) begin
      ptr_q <= AW'(pos_nxt);
    end else if (cmd_i.shift_step) begin
      ptr_q <= AW'(ptr_nxt);
    end
    if (cmd_i.res_write) begin
      res_word_q   <= cmd_i.res_from_rd ? rd_ext[DATA_W-1:0] : '0;
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.out_load) begin
      out_q.word_out <= res_word_q;
      out_q.length   <= LENGTH_W'(count_q);
      out_q.status   <= res_status_q;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.do_append) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/alen_ctrl.sv =====
// Controller state machine of the array list engine.
`timescale 1ns / 1ps
`default_nettype none

module alen_ctrl
  import alen_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  alen_stat_t stat_i,
  output logic       in_stall_o,
  output alen_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_DONE   = 5'b10000
  } alen_state_e;

  alen_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        cmd_o.res_write = 1'b1;
        unique case (stat_i.op)
          OP_APPEND: begin
            if (stat_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.do_append = 1'b1;
            end
          end
          OP_READ: begin
            if (!stat_i.pos_ok) begin
              cmd_o.res_status = ST_RANGE;
            end else begin
              cmd_o.res_write = 1'b0;
              cmd_o.rd_pos    = 1'b1;
              state_d = S_RDWAIT;
            end
          end
          OP_REMOVE: begin
            if (!stat_i.pos_ok) begin
              cmd_o.res_status = ST_RANGE;
            end else if (stat_i.init_more) begin
              cmd_o.res_write   = 1'b0;
              cmd_o.rd_ptr_init = 1'b1;
              state_d = S_SHIFT;
            end else begin
              // Removing the last entry needs no shift.
              cmd_o.cnt_dec = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_RDWAIT: begin
        cmd_o.res_write   = 1'b1;
        cmd_o.res_from_rd = 1'b1;
        state_d = S_DONE;
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (!stat_i.step_more) begin
          cmd_o.cnt_dec   = 1'b1;
          cmd_o.res_write = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

`default_nettype wire

// ===== rtl/array_list_engine_core.sv =====
// Array list engine top level: a dense ordered word list with append, read and remove.
//
// The block keeps up to DEPTH words of WORD_WIDTH bits in a single-port-write,
// single-port-read memory plus an entry count, and handles one item at a time.
// An item is taken in one cycle and decoded in the next; an append, any
// out-of-range or full request, a remove of the last entry and the unused
// op code finish there, and a read adds a state for the registered memory
// read. A remove at position p shifts the count - p - 1 later entries down
// through the memory's one read and one write port, one entry per cycle.
// Results sit in an output register, so the next item is taken while a
// finished result still waits downstream.
// The memory needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module array_list_engine_core
  import alen_pkg::*;
#(
  parameter int DEPTH      = ALEN_DEPTH,
  parameter int WORD_WIDTH = ALEN_WORD_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  alen_in_t  in_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output alen_out_t out_data_o,
  output logic      out_valid_o,
  input  logic      out_stall_i
);

  alen_cmd_t  cmd;
  alen_stat_t stat;

  alen_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  alen_dpath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o)
  );

endmodule

`default_nettype wire

// ===== rtl/alen_checker.sv =====
// Port-level assertion checker for the array list engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "array_list_engine_core_macros.svh"

module alen_checker
  import alen_pkg::*;
#(
  parameter int DEPTH = ALEN_DEPTH
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input alen_out_t out_data_o,
  input logic      out_valid_o,
  input logic      out_stall_i
);

  localparam logic [LENGTH_W-1:0] DEPTH_LEN = LENGTH_W'(DEPTH);
  localparam bit LEN_WRAPS = DEPTH > 255;

  // A stalled result transfer must hold its value.
  `ALEN_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // Only a successful read returns a word; failures report zero.
  `ALEN_ASSERT(a_fail_zero, out_valid_o && out_data_o.status != ST_OK |-> out_data_o.word_out == '0, "failed operation returned a nonzero word")

  // A full report means the list holds exactly DEPTH entries.
  `ALEN_ASSERT(a_full_len, out_valid_o && out_data_o.status == ST_FULL |-> out_data_o.length == DEPTH_LEN, "full status with wrong length")

  // The length never exceeds the store size.
  `ALEN_ASSERT(a_len_max, out_valid_o |-> LEN_WRAPS || out_data_o.length <= DEPTH_LEN, "length beyond store size")

  // Once reset has been seen at a clock edge, nothing is presented and the
  // input is open at the next edge.
  `ALEN_ASSERT_RST(a_rst_quiet, !rst_ni |=> !out_valid_o && !in_stall_o, "outputs active during reset")

endmodule

bind array_list_engine_core alen_checker #(
  .DEPTH (DEPTH)
) u_alen_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the array list engine: append, read and remove with shifting.
`timescale 1ns / 1ps

module testbench;
  import alen_pkg::*;

  localparam int DEPTH          = ALEN_DEPTH;
  localparam int CYCLE_LIMIT    = 400_000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 160;

  // The op field has one code that the package leaves unnamed.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n;
  alen_in_t  in_data;
  logic      in_valid;
  logic      in_stall;
  alen_out_t out_data;
  logic      out_valid;
  logic      out_stall;

  array_list_engine_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_data_i  (in_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .out_data_o (out_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall)
  );

  // Predicted list contents and length.
  logic [DATA_W-1:0] list_words [DEPTH];
  int unsigned       list_len;
  alen_out_t         pending_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  int holdoff_left;
  int errors;
  int cycles;
  int n_append, n_read, n_remove, n_unused, n_range, n_full, n_results, peak_len;

  typedef struct {
    alen_op_e          op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] word;
    bit                typed;
    logic [DATA_W-1:0] exp_word;
    logic [LENGTH_W-1:0] exp_len;
    alen_status_e      exp_status;
  } dir_row_t;

  // Rows marked typed carry the result that can be read off directly; the rest
  // go through the list predictor.
  dir_row_t dir_rows [18] = '{
    '{OP_READ,   7'd0,   32'h0,         1'b1, 32'h0,         8'd0, ST_RANGE},
    '{OP_REMOVE, 7'd127, 32'h0,         1'b1, 32'h0,         8'd0, ST_RANGE},
    '{alen_op_e'(OP_UNUSED), 7'd0, 32'h0, 1'b1, 32'h0,       8'd0, ST_OK},
    '{OP_APPEND, 7'd127, 32'hFFFF_FFFF, 1'b1, 32'h0,         8'd1, ST_OK},
    '{OP_APPEND, 7'd0,   32'h0,         1'b1, 32'h0,         8'd2, ST_OK},
    '{OP_APPEND, 7'd64,  32'hA5A5_5A5A, 1'b1, 32'h0,         8'd3, ST_OK},
    '{OP_READ,   7'd0,   32'h0,         1'b1, 32'hFFFF_FFFF, 8'd3, ST_OK},
    '{OP_READ,   7'd2,   32'hFFFF_FFFF, 1'b1, 32'hA5A5_5A5A, 8'd3, ST_OK},
    '{OP_READ,   7'd3,   32'h0,         1'b1, 32'h0,         8'd3, ST_RANGE},
    '{OP_READ,   7'd127, 32'h0,         1'b1, 32'h0,         8'd3, ST_RANGE},
    '{OP_REMOVE, 7'd0,   32'h0,         1'b0, 32'h0,         8'd0, ST_OK},
    '{OP_READ,   7'd0,   32'h0,         1'b0, 32'h0,         8'd0, ST_OK},
    '{OP_READ,   7'd1,   32'h0,         1'b0, 32'h0,         8'd0, ST_OK},
    '{OP_REMOVE, 7'd1,   32'h0,         1'b0, 32'h0,         8'd0, ST_OK},
    '{OP_REMOVE, 7'd64,  32'h0,         1'b1, 32'h0,         8'd1, ST_RANGE},
    '{alen_op_e'(OP_UNUSED), 7'd127, 32'hFFFF_FFFF, 1'b1, 32'h0, 8'd1, ST_OK},
    '{OP_REMOVE, 7'd0,   32'h0,         1'b1, 32'h0,         8'd0, ST_OK},
    '{OP_READ,   7'd0,   32'h0,         1'b1, 32'h0,         8'd0, ST_RANGE}
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one operation to the predicted list and returns its result.
  function automatic alen_out_t apply_list_op(alen_in_t item);
    alen_out_t   res;
    int unsigned idx;
    res = '{word_out: '0, length: '0, status: ST_OK};
    case (item.op)
      OP_APPEND: begin
        if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_len] = item.word_in;
          list_len++;
        end
      end
      OP_READ: begin
        if (item.position >= list_len) res.status = ST_RANGE;
        else res.word_out = list_words[item.position];
      end
      OP_REMOVE: begin
        if (item.position >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (idx = item.position; idx + 1 < list_len; idx++) begin
            list_words[idx] = list_words[idx + 1];
          end
          list_len--;
        end
      end
      default: ;
    endcase
    res.length = list_len[LENGTH_W-1:0];
    return res;
  endfunction

  // Offers one item, waits for its transfer and records what should come back.
  task automatic offer_item(input alen_in_t item, input bit typed, input alen_out_t typed_res);
    alen_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predicted = apply_list_op(item);
    case (item.op)
      OP_APPEND: n_append++;
      OP_READ:   n_read++;
      OP_REMOVE: n_remove++;
      default:   n_unused++;
    endcase
    if (predicted.status == ST_RANGE) n_range++;
    if (predicted.status == ST_FULL) n_full++;
    if (list_len > peak_len) peak_len = list_len;
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Random operation, mostly aimed at positions that exist in the list.
  function automatic alen_in_t pick_list_item(int append_pct);
    alen_in_t item;
    int       roll;
    roll = $urandom_range(99);
    item.word_in  = $urandom;
    item.position = POS_W'($urandom_range(127));
    if (roll < 4) item.op = alen_op_e'(OP_UNUSED);
    else if (roll < 4 + append_pct) item.op = OP_APPEND;
    else if (roll < 4 + append_pct + (96 - append_pct) / 2) item.op = OP_READ;
    else item.op = OP_REMOVE;
    if (list_len > 0 && $urandom_range(99) < 85) begin
      item.position = POS_W'($urandom_range(list_len - 1));
    end
    return item;
  endfunction

  task automatic run_mixed(input int count);
    alen_in_t item;
    repeat (count) begin
      item = pick_list_item(list_len < 96 ? 45 : 25);
      offer_item(item, 1'b0, '0);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    alen_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, actual word %h length %0d status %0d",
                 $time, out_data.word_out, out_data.length, out_data.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.word_out !== want.word_out) begin
          $display("%0t: word_out expected %h actual %h",
                   $time, want.word_out, out_data.word_out);
          errors++;
        end
        if (out_data.length !== want.length) begin
          $display("%0t: length expected %0d actual %0d", $time, want.length, out_data.length);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    alen_in_t  item;
    alen_out_t typed_res;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_left   = 0;
    errors         = 0;
    cycles         = 0;
    list_len       = 0;
    peak_len       = 0;
    n_append = 0; n_read = 0; n_remove = 0; n_unused = 0;
    n_range = 0; n_full = 0; n_results = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[r]) begin
      item      = '{op: dir_rows[r].op, position: dir_rows[r].pos, word_in: dir_rows[r].word};
      typed_res = '{word_out: dir_rows[r].exp_word, length: dir_rows[r].exp_len,
                    status: dir_rows[r].exp_status};
      offer_item(item, dir_rows[r].typed, typed_res);
    end
    drain_results();

    // Back-to-back transfers on both sides.
    run_mixed(150);
    drain_results();

    send_idle_pct = 82;
    run_mixed(120);
    drain_results();

    // The long hold-off lets the block fill up while items keep coming.
    send_idle_pct  = 0;
    recv_stall_pct = 82;
    holdoff_left   = HOLDOFF_CYCLES;
    run_mixed(120);
    drain_results();

    // Fill the store, push past full, then remove from the front for the longest shifts.
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    while (list_len < DEPTH) begin
      item = '{op: OP_APPEND, position: POS_W'($urandom_range(127)), word_in: $urandom};
      offer_item(item, 1'b0, '0);
    end
    repeat (4) begin
      item = '{op: OP_APPEND, position: POS_W'($urandom_range(127)), word_in: $urandom};
      offer_item(item, 1'b0, '0);
    end
    item = '{op: OP_READ, position: 7'd127, word_in: $urandom};
    offer_item(item, 1'b0, '0);
    repeat (3) begin
      item = '{op: OP_REMOVE, position: 7'd0, word_in: $urandom};
      offer_item(item, 1'b0, '0);
    end
    item = '{op: OP_REMOVE, position: POS_W'(list_len - 1), word_in: $urandom};
    offer_item(item, 1'b0, '0);
    drain_results();

    run_mixed(170);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d appends, %0d reads, %0d removes, %0d unused ops; %0d results checked.",
             n_append, n_read, n_remove, n_unused, n_results);
    $display("Saw %0d out-of-range and %0d full requests; the list peaked at %0d entries.",
             n_range, n_full, peak_len);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
